### rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CAP_W     = 5;
    localparam int PRIO_W    = 16;
    localparam int VAL_W     = 8;
    localparam int STAT_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic        [VAL_W-1:0]  val;
    } t_entry;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage
`default_nettype wire

### rtl/sorted_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue kept sorted in a row of shifting cells, smallest first.
// ----------------------------------------------------------------------------
// One command is taken per clock; busy stays low. The result of a command
// appears on the result ports with o_valid for exactly one cycle, in the cycle
// after start, and must be taken then. Every cell compares its entry with the
// new priority in parallel, and the row shifts in one step for an enqueue or
// a dequeue whatever the fill level.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_func,
    input  wire logic signed [PRIO_W-1:0] i_in_priority,
    input  wire logic        [VAL_W-1:0]  i_in_value,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic        [CAP_W-1:0]  i_cfg_data,
    output logic                          o_valid,
    output logic             [STAT_W-1:0] o_status,
    output logic             [VAL_W-1:0]  o_out_value,
    output logic signed      [PRIO_W-1:0] o_out_priority,
    output logic             [CNT_W-1:0]  o_entry_count,
    output logic             [VAL_W-1:0]  o_front_value,
    output logic signed      [PRIO_W-1:0] o_front_priority
);

    localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_status          r_status;
    t_status          n_status;
    t_entry           r_out;
    t_entry           n_out;
    t_entry           r_front;
    t_entry           n_front;

    t_cell_ctl        ctl;
    t_entry           new_entry;
    t_entry           cell_q [DEPTH];
    logic             flag   [DEPTH];
    logic             accept;
    logic             full;
    logic [CW-1:0]    cap_eff;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign new_entry.prio = i_in_priority;
    assign new_entry.val  = i_in_value;

    assign cap_eff = (r_cap == '0) ? CW'(1) : CW'(r_cap);
    assign full    = (r_count >= CNT_W'(DEPTH)) || (CW'(r_count) >= cap_eff);

    assign ctl.enq = accept && (i_func == FUNC_ENQ) && !full;
    assign ctl.deq = accept && (i_func == FUNC_DEQ) && (r_count != '0);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry c_left;
        t_entry c_right;
        logic   c_left_flag;
        if (g == 0) begin : g_first
            assign c_left      = new_entry;
            assign c_left_flag = 1'b0;
        end else begin : g_mid
            assign c_left      = cell_q[g-1];
            assign c_left_flag = flag[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign c_right = cell_q[g];
        end else begin : g_body
            assign c_right = cell_q[g+1];
        end
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_new       (new_entry),
            .i_left      (c_left),
            .i_right     (c_right),
            .i_left_flag (c_left_flag),
            .i_occupied  (CNT_W'(g) < r_count),
            .o_flag      (flag[g]),
            .o_entry     (cell_q[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_out    = '0;
        n_front  = (r_count != '0) ? cell_q[0] : '0;
        if (i_func == FUNC_ENQ) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
                n_front = flag[0] ? new_entry : cell_q[0];
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_W'(1);
                n_out   = cell_q[0];
                n_front = (r_count > CNT_W'(1)) ? cell_q[1] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_out    <= n_out;
            r_front  <= n_front;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_out_value      = r_out.val;
    assign o_out_priority   = r_out.prio;
    assign o_entry_count    = r_count;
    assign o_front_value    = r_front.val;
    assign o_front_priority = r_front.prio;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the built depth.");

    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("An accepted command produced no result beat.");

    a_enq_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.enq |=> (r_count == $past(r_count) + CNT_W'(1)) && (o_status == ST_DONE))
        else $error("An enqueue did not grow the queue by one entry.");

    a_deq_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.deq |=> (r_count == $past(r_count) - CNT_W'(1)) && (o_status == ST_DONE))
        else $error("A dequeue did not shrink the queue by one entry.");

endmodule
`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, keeps it, takes the new entry,
// or takes a neighbor's entry as the row shifts.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_new,
    input  wire t_entry    i_left,
    input  wire t_entry    i_right,
    input  wire logic      i_left_flag,
    input  wire logic      i_occupied,
    output logic           o_flag,
    output t_entry         o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_flag  = !i_occupied || (r_entry.prio > i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq && o_flag) begin
            n_entry = i_left_flag ? i_left : i_new;
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

### tb/sorted_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker
// Watches the command, configuration and result ports of the sorted
// priority queue. It keeps its own sorted list of entries and its own copy
// of the capacity register, works out the result of every accepted command
// and compares each result beat field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_busy,
    input  wire logic                     i_func,
    input  wire logic signed [PRIO_W-1:0] i_in_priority,
    input  wire logic        [VAL_W-1:0]  i_in_value,
    input  wire logic                     i_cfg_valid,
    input  wire logic                     i_cfg_ready,
    input  wire logic        [CAP_W-1:0]  i_cfg_data,
    input  wire logic                     i_valid,
    input  wire logic        [STAT_W-1:0] i_status,
    input  wire logic        [VAL_W-1:0]  i_out_value,
    input  wire logic signed [PRIO_W-1:0] i_out_priority,
    input  wire logic        [CNT_W-1:0]  i_entry_count,
    input  wire logic        [VAL_W-1:0]  i_front_value,
    input  wire logic signed [PRIO_W-1:0] i_front_priority,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        t_status                  status;
        logic        [VAL_W-1:0]  out_value;
        logic signed [PRIO_W-1:0] out_prio;
        logic        [CNT_W-1:0]  count;
        logic        [VAL_W-1:0]  front_value;
        logic signed [PRIO_W-1:0] front_prio;
    } t_queue_result;

    t_entry           queued_entries[$];
    t_queue_result    awaited_results[$];
    logic [CAP_W-1:0] capacity_reg;

    function automatic int capacity_limit();
        int lim;
        lim = int'(capacity_reg);
        if (lim == 0) begin
            lim = 1;
        end
        if (lim > DEPTH) begin
            lim = DEPTH;
        end
        return lim;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        o_fail_count++;
    endtask

    task automatic apply_queue_command(
        input logic                     func,
        input logic signed [PRIO_W-1:0] prio,
        input logic        [VAL_W-1:0]  val
    );
        t_queue_result res;
        t_entry        item;
        int            pos;
        res = '0;
        res.status = ST_DONE;
        if (func == FUNC_ENQ) begin
            if (queued_entries.size() >= capacity_limit()) begin
                res.status = ST_FULL;
            end else begin
                item.prio = prio;
                item.val  = val;
                pos = queued_entries.size();
                while (pos > 0 && $signed(queued_entries[pos-1].prio) > $signed(prio)) begin
                    pos--;
                end
                queued_entries.insert(pos, item);
            end
        end else if (queued_entries.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            item = queued_entries.pop_front();
            res.out_value = item.val;
            res.out_prio  = item.prio;
        end
        res.count = CNT_W'(queued_entries.size());
        if (queued_entries.size() > 0) begin
            res.front_value = queued_entries[0].val;
            res.front_prio  = queued_entries[0].prio;
        end
        awaited_results.push_back(res);
    endtask

    task automatic check_result();
        t_queue_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch("result beat with none awaited", 1, 0);
            return;
        end
        want = awaited_results.pop_front();
        if (i_status !== want.status) begin
            report_mismatch("status", int'(i_status), int'(want.status));
        end
        if (i_out_value !== want.out_value) begin
            report_mismatch("out_value", int'(i_out_value), int'(want.out_value));
        end
        if (i_out_priority !== want.out_prio) begin
            report_mismatch("out_priority", int'(i_out_priority), int'(want.out_prio));
        end
        if (i_entry_count !== want.count) begin
            report_mismatch("entry_count", int'(i_entry_count), int'(want.count));
        end
        if (i_front_value !== want.front_value) begin
            report_mismatch("front_value", int'(i_front_value), int'(want.front_value));
        end
        if (i_front_priority !== want.front_prio) begin
            report_mismatch("front_priority", int'(i_front_priority),
                            int'(want.front_prio));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            queued_entries.delete();
            awaited_results.delete();
            capacity_reg = CAP_RESET;
        end else begin
            if (i_valid) begin
                check_result();
            end
            if (i_start && !i_busy) begin
                apply_queue_command(i_func, i_in_priority, i_in_value);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                capacity_reg = i_cfg_data;
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

### tb/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_tb
// Drives enqueue and dequeue commands into the sorted priority queue under a
// range of capacity settings, first a short directed run and then random
// phases that fill and drain the queue, most with gaps of random length. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH_DEF + 1);

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_func;
    logic signed [PRIO_W-1:0] i_in_priority;
    logic        [VAL_W-1:0]  i_in_value;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic        [CAP_W-1:0]  i_cfg_data;
    logic                     o_valid;
    logic        [STAT_W-1:0] o_status;
    logic        [VAL_W-1:0]  o_out_value;
    logic signed [PRIO_W-1:0] o_out_priority;
    logic        [CNT_W-1:0]  o_entry_count;
    logic        [VAL_W-1:0]  o_front_value;
    logic signed [PRIO_W-1:0] o_front_priority;
    int                       fail_count;
    int                       pending_count;

    always #4 i_clk = ~i_clk;

    sorted_priority_queue_unit #(
        .DEPTH(DEPTH_DEF)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_in_priority   (i_in_priority),
        .i_in_value      (i_in_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_entry_count   (o_entry_count),
        .o_front_value   (o_front_value),
        .o_front_priority(o_front_priority)
    );

    sorted_priority_queue_checker #(
        .DEPTH(DEPTH_DEF)
    ) u_queue_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (i_func),
        .i_in_priority   (i_in_priority),
        .i_in_value      (i_in_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (o_valid),
        .i_status        (o_status),
        .i_out_value     (o_out_value),
        .i_out_priority  (o_out_priority),
        .i_entry_count   (o_entry_count),
        .i_front_value   (o_front_value),
        .i_front_priority(o_front_priority),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    // Drive one command beat and hold it until the block takes it.
    task automatic issue_command(
        input logic                     func,
        input logic signed [PRIO_W-1:0] prio,
        input logic        [VAL_W-1:0]  val
    );
        @(negedge i_clk);
        start         <= 1'b1;
        i_func        <= func;
        i_in_priority <= prio;
        i_in_value    <= val;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_func        <= 1'($urandom);
            i_in_priority <= PRIO_W'($urandom);
            i_in_value    <= VAL_W'($urandom);
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= CAP_W'($urandom);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Small priorities collide often, which exercises the arrival order of ties.
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                v = int'($urandom_range(0, 7)) - 4;
                return PRIO_W'(v);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'shFFFF;
                    default: return 16'sh0000;
                endcase
            end
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int items);
        int   enq_pct;
        bit   steady;
        logic func;
        write_capacity(cap);
        case ($urandom_range(0, 2))
            0: enq_pct = 25;
            1: enq_pct = 50;
            default: enq_pct = 80;
        endcase
        steady = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < items; n++) begin
            if (n == items / 2) begin
                enq_pct = 100 - enq_pct;
            end
            func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            issue_command(func, pick_priority(), VAL_W'($urandom));
            if (!steady) begin
                hold_off(pick_gap());
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [CAP_W-1:0] phase_caps[11];
        phase_caps = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd15, 5'd3, 5'd8, 5'd16, 5'd31, 5'd5};
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_func        = FUNC_ENQ;
        i_in_priority = '0;
        i_in_value    = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue_command(FUNC_DEQ, 16'sh0000, 8'h00);
        issue_command(FUNC_ENQ, 16'sh7FFF, 8'hFF);
        issue_command(FUNC_ENQ, 16'sh8000, 8'h00);
        issue_command(FUNC_ENQ, 16'sh0000, 8'hAA);
        issue_command(FUNC_ENQ, 16'sh0000, 8'h55);
        issue_command(FUNC_ENQ, 16'shFFFF, 8'h0F);
        issue_command(FUNC_ENQ, 16'sh0001, 8'hF0);
        repeat (7) issue_command(FUNC_DEQ, 16'sh7FFF, 8'hFF);

        // A capacity of zero behaves as a capacity of one.
        write_capacity(5'd0);
        issue_command(FUNC_ENQ, 16'sh0005, 8'h01);
        issue_command(FUNC_ENQ, -16'sh0005, 8'h02);
        issue_command(FUNC_DEQ, 16'sh0000, 8'h00);
        issue_command(FUNC_DEQ, 16'sh0000, 8'h00);

        // Lowering the capacity below the count keeps every entry.
        write_capacity(5'd16);
        issue_command(FUNC_ENQ, 16'sh0064, 8'h11);
        issue_command(FUNC_ENQ, 16'sh0032, 8'h22);
        issue_command(FUNC_ENQ, 16'sh004B, 8'h33);
        write_capacity(5'd1);
        issue_command(FUNC_ENQ, 16'sh000A, 8'h44);
        issue_command(FUNC_DEQ, 16'sh0000, 8'h00);
        issue_command(FUNC_ENQ, 16'sh000A, 8'h55);

        foreach (phase_caps[i]) begin
            run_random_phase(phase_caps[i], 60);
        end
        run_random_phase(CAP_W'($urandom_range(0, 31)), 60);

        drain_results();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
